// ===== rtl/sas_pkg.sv =====
`default_nettype none
package sas_pkg;

  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int INDEX_W = 4;
  localparam int SNAP_ID_W = 5;
  localparam int TAKEN_ID_W = 4;
  localparam int LEN_W = 5;

  localparam int ARRAY_LENGTH_DEF = 16;
  localparam int MAX_SNAPSHOTS_DEF = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_SET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SNAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/sas_ram.sv =====
`default_nettype none
module sas_ram
  import sas_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/snapshot_array_store.sv =====
// versioned word array with snapshots
// input channel (in_valid/in_ready) carries one transaction per item:
//   in_kind set writes in_value to live entry in_index, snap copies the whole
//   live array into the next snapshot slot, get reads in_index from snapshot
//   in_snap_id (the current snapshot count selects the live array)
// output channel (out_valid/out_ready) returns one transaction per item:
//   out_read_value, out_taken_id and out_error
// cfg_data sets the number of entries in use; cfg_ready is always high
// a snap runs the copy loop, one live-memory read and one snapshot-memory
//   write a cycle
// a finished result loads into the output register and raises out_valid
// after reset the live memory is cleared, one entry a cycle, with in_ready
//   low; snapshot count and length reset
// a stalled receiver holds the result in the output register; one more item
//   is accepted and processed meanwhile, its result waits until the output
//   register frees up
`default_nettype none
module snapshot_array_store
  import sas_pkg::*;
#(
  parameter int ARRAY_LENGTH = ARRAY_LENGTH_DEF,
  parameter int MAX_SNAPSHOTS = MAX_SNAPSHOTS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [KIND_W-1:0]       in_kind,
  input  wire logic [INDEX_W-1:0]      in_index,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic [SNAP_ID_W-1:0]    in_snap_id,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [WORD_W-1:0]     out_read_value,
  output logic [TAKEN_ID_W-1:0]        out_taken_id,
  output logic                         out_error,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [LEN_W-1:0]        cfg_data
);

  localparam int LAW = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
  localparam int SDEPTH = MAX_SNAPSHOTS * ARRAY_LENGTH;
  localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CW = $clog2(MAX_SNAPSHOTS + 1);
  localparam logic [LAW-1:0] LAST_ENTRY = LAW'(ARRAY_LENGTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [LAW-1:0]     cnt_r;
  logic [CW-1:0]      count_r;
  logic [LEN_W-1:0]   len_r;
  logic [SAW-1:0]     base_r;
  logic               live_sel_r;
  logic [WORD_W-1:0]  res_rd_r;
  logic [TAKEN_ID_W-1:0] res_tid_r;
  logic               res_err_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_rd_r;
  logic [TAKEN_ID_W-1:0] out_tid_r;
  logic               out_err_r;

  logic accept, idx_ok, snap_ok, sid_ok, sid_live, res_load;
  logic set_go, get_go, snap_go, copy_last, clear_last;
  logic              live_wr_en, live_rd_en, snap_wr_en, snap_rd_en;
  logic [LAW-1:0]    live_wr_addr, live_rd_addr;
  logic [WORD_W-1:0] live_wr_data, live_rd_data, snap_rd_data;
  logic [SAW-1:0]    snap_wr_addr, snap_rd_addr;

  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  assign idx_ok = (32'(in_index) < 32'(len_r)) && (32'(in_index) < ARRAY_LENGTH);
  assign snap_ok = 32'(count_r) < MAX_SNAPSHOTS;
  assign sid_ok = 32'(in_snap_id) <= 32'(count_r);
  assign sid_live = 32'(in_snap_id) == 32'(count_r);

  assign set_go = accept && (in_kind == KIND_SET) && idx_ok;
  assign get_go = accept && (in_kind == KIND_GET) && idx_ok && sid_ok;
  assign snap_go = accept && (in_kind == KIND_SNAP) && snap_ok;

  assign copy_last = (state_r == ST_COPY) && (cnt_r == LAST_ENTRY);
  assign clear_last = (state_r == ST_CLEAR) && (cnt_r == LAST_ENTRY);
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    live_wr_en = (state_r == ST_CLEAR) || set_go;
    live_wr_addr = (state_r == ST_CLEAR) ? cnt_r : LAW'(in_index);
    live_wr_data = (state_r == ST_CLEAR) ? '0 : $unsigned(in_value);
    live_rd_en = (get_go && sid_live) || snap_go || ((state_r == ST_COPY) && !copy_last);
    priority if (state_r == ST_COPY) begin
      live_rd_addr = LAW'(cnt_r + 1'b1);
    end else if (snap_go) begin
      live_rd_addr = '0;
    end else begin
      live_rd_addr = LAW'(in_index);
    end
    snap_wr_en = (state_r == ST_COPY);
    snap_wr_addr = base_r + SAW'(cnt_r);
    snap_rd_en = get_go && !sid_live;
    snap_rd_addr = SAW'(32'(in_snap_id) * ARRAY_LENGTH + 32'(in_index));
  end

  sas_ram #(
    .DEPTH (ARRAY_LENGTH),
    .AW    (LAW)
  ) u_live_ram (
    .clk     (clk),
    .wr_en   (live_wr_en),
    .wr_addr (live_wr_addr),
    .wr_data (live_wr_data),
    .rd_en   (live_rd_en),
    .rd_addr (live_rd_addr),
    .rd_data (live_rd_data)
  );

  sas_ram #(
    .DEPTH (SDEPTH),
    .AW    (SAW)
  ) u_snap_ram (
    .clk     (clk),
    .wr_en   (snap_wr_en),
    .wr_addr (snap_wr_addr),
    .wr_data (live_rd_data),
    .rd_en   (snap_rd_en),
    .rd_addr (snap_rd_addr),
    .rd_data (snap_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      count_r <= '0;
      len_r <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (clear_last) begin
            cnt_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= LAW'(cnt_r + 1'b1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_rd_r <= '0;
            res_tid_r <= '0;
            res_err_r <= !(set_go || get_go || snap_go);
            live_sel_r <= sid_live;
            base_r <= SAW'(32'(count_r) * ARRAY_LENGTH);
            cnt_r <= '0;
            priority if (get_go) begin
              state_r <= ST_READ;
            end else if (snap_go) begin
              state_r <= ST_COPY;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          res_rd_r <= live_sel_r ? live_rd_data : snap_rd_data;
          state_r <= ST_DONE;
        end
        ST_COPY: begin
          if (copy_last) begin
            cnt_r <= '0;
            count_r <= CW'(count_r + 1'b1);
            res_tid_r <= TAKEN_ID_W'(count_r);
            state_r <= ST_DONE;
          end else begin
            cnt_r <= LAW'(cnt_r + 1'b1);
          end
        end
        ST_DONE: begin
          if (res_load) begin
            out_rd_r <= res_rd_r;
            out_tid_r <= res_tid_r;
            out_err_r <= res_err_r;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_read_value = $signed(out_rd_r);
  assign out_taken_id = out_tid_r;
  assign out_error = out_err_r;

endmodule
`default_nettype wire

// ===== test/tb_snapshot_array_store.sv =====
`default_nettype none
module tb_snapshot_array_store;
  import sas_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_WORDS = ARRAY_LENGTH_DEF;
  localparam int NUM_SNAPS = MAX_SNAPSHOTS_DEF;
  localparam int SETTLE_CYCLES = NUM_WORDS + 8;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       index;
    logic signed [WORD_W-1:0] value;
    logic [SNAP_ID_W-1:0]     snap_id;
  } store_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [TAKEN_ID_W-1:0]    taken_id;
    logic                     error;
  } store_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind = '0;
  logic [INDEX_W-1:0]       in_index = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic [SNAP_ID_W-1:0]     in_snap_id = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] out_read_value;
  logic [TAKEN_ID_W-1:0]    out_taken_id;
  logic                     out_error;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LEN_W-1:0]         cfg_data = '0;

  snapshot_array_store DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_index       (in_index),
    .in_value       (in_value),
    .in_snap_id     (in_snap_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_taken_id   (out_taken_id),
    .out_error      (out_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [WORD_W-1:0]  live_word [NUM_WORDS];
  logic [WORD_W-1:0]  frozen_word [NUM_SNAPS][NUM_WORDS];
  logic [LEN_W-1:0]   frozen_count;
  logic [LEN_W-1:0]   length_reg;

  store_req_t  pending_req [$];
  store_resp_t expected_resp [$];
  int          fail_count = 0;
  bit          no_idle = 1'b0;

  // generator-side view of length and snapshot count
  int gen_len = NUM_WORDS;
  int gen_snaps = 0;

  function automatic store_resp_t apply_request(input store_req_t req);
    store_resp_t resp;
    int          eff;
    bit          idx_ok;
    resp = '0;
    eff = (length_reg > NUM_WORDS) ? NUM_WORDS : int'(length_reg);
    idx_ok = int'(req.index) < eff;
    case (req.kind)
      KIND_SET: begin
        if (idx_ok) live_word[req.index] = req.value;
        else resp.error = 1'b1;
      end
      KIND_SNAP: begin
        if (frozen_count < NUM_SNAPS) begin
          for (int i = 0; i < NUM_WORDS; i++)
            frozen_word[frozen_count[TAKEN_ID_W-1:0]][i] = live_word[i];
          resp.taken_id = frozen_count[TAKEN_ID_W-1:0];
          frozen_count = frozen_count + 1'b1;
        end else begin
          resp.error = 1'b1;
        end
      end
      KIND_GET: begin
        if (!idx_ok || req.snap_id > frozen_count) resp.error = 1'b1;
        else if (req.snap_id == frozen_count) resp.read_value = live_word[req.index];
        else resp.read_value = frozen_word[req.snap_id[TAKEN_ID_W-1:0]][req.index];
      end
      default: resp.error = 1'b1;
    endcase
    return resp;
  endfunction

  // driver
  store_req_t cur_req;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_resp.push_back(apply_request(cur_req));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_req.size() != 0 && !no_idle && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          cur_req = pending_req.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_req.kind;
          in_index <= cur_req.index;
          in_value <= cur_req.value;
          in_snap_id <= cur_req.snap_id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  store_resp_t want;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transaction: read_value=%0d taken_id=%0d error=%0b",
                     out_read_value, out_taken_id, out_error);
        end else begin
          want = expected_resp.pop_front();
          if (out_read_value !== want.read_value || out_taken_id !== want.taken_id ||
              out_error !== want.error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp read_value=%0d taken_id=%0d error=%0b, got %0d %0d %0b",
                       want.read_value, want.taken_id, want.error,
                       out_read_value, out_taken_id, out_error);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_item(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
                          input logic [WORD_W-1:0] v, input logic [SNAP_ID_W-1:0] sid);
    store_req_t req;
    req.kind = k;
    req.index = idx;
    req.value = v;
    req.snap_id = sid;
    if (k == KIND_SNAP && gen_snaps < NUM_SNAPS) gen_snaps++;
    pending_req.push_back(req);
  endtask

  task automatic add_random(input int count);
    int                   eff;
    int                   pick;
    logic [KIND_W-1:0]    k;
    logic [INDEX_W-1:0]   idx;
    logic [WORD_W-1:0]    v;
    logic [SNAP_ID_W-1:0] sid;
    for (int n = 0; n < count; n++) begin
      eff = (gen_len > NUM_WORDS) ? NUM_WORDS : gen_len;
      pick = $urandom_range(0, 99);
      idx = INDEX_W'($urandom_range(0, 15));
      if (eff > 0 && $urandom_range(0, 99) < 85) idx = INDEX_W'($urandom_range(0, eff - 1));
      v = $urandom;
      case ($urandom_range(0, 9))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        default: ;
      endcase
      sid = SNAP_ID_W'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        k = KIND_SET;
      end else if (pick < 94) begin
        k = KIND_GET;
        pick = $urandom_range(0, 99);
        if (pick < 70) sid = SNAP_ID_W'($urandom_range(0, gen_snaps));
        else if (pick < 85) sid = SNAP_ID_W'(gen_snaps);
      end else if (pick < 96) begin
        k = KIND_SNAP;
      end else begin
        k = KIND_UNUSED;
      end
      add_item(k, idx, v, sid);
    end
  endtask

  task automatic wait_idle();
    while (pending_req.size() != 0 || in_valid || expected_resp.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_reg = len;
    gen_len = int'(len);
  endtask

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      live_word[i] = '0;
      for (int s = 0; s < NUM_SNAPS; s++) frozen_word[s][i] = '0;
    end
    frozen_count = '0;
    length_reg = LEN_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents, extremes, snapshot versus live reads
    add_item(KIND_GET, 4'd0, 32'h0, 5'd0);
    add_item(KIND_GET, 4'd15, 32'hffff_ffff, 5'd0);
    add_item(KIND_SET, 4'd0, 32'h7fff_ffff, 5'd31);
    add_item(KIND_SET, 4'd15, 32'h8000_0000, 5'd0);
    add_item(KIND_SET, 4'd5, 32'hffff_ffff, 5'd0);
    add_item(KIND_GET, 4'd1, 32'h0, 5'd1);
    add_item(KIND_SNAP, 4'd15, 32'hffff_ffff, 5'd31);
    add_item(KIND_SET, 4'd0, 32'h1, 5'd0);
    add_item(KIND_GET, 4'd0, 32'h0, 5'd0);
    add_item(KIND_GET, 4'd0, 32'h0, 5'd1);
    add_item(KIND_GET, 4'd15, 32'h0, 5'd0);
    add_item(KIND_GET, 4'd5, 32'h0, 5'd2);
    add_item(KIND_GET, 4'd5, 32'h0, 5'd31);
    add_item(KIND_UNUSED, 4'd15, 32'hffff_ffff, 5'd31);
    add_item(KIND_UNUSED, 4'd0, 32'h0, 5'd0);
    add_item(KIND_SNAP, 4'd0, 32'h0, 5'd0);
    add_random(300);
    wait_idle();

    // shortest nonzero length, then zero length rejects every set and get
    write_length(5'd1);
    add_item(KIND_SET, 4'd1, 32'h1234_5678, 5'd0);
    add_item(KIND_SET, 4'd0, 32'h5555_aaaa, 5'd0);
    add_item(KIND_GET, 4'd0, 32'h0, 5'd2);
    add_item(KIND_GET, 4'd1, 32'h0, 5'd2);
    add_random(150);
    wait_idle();

    write_length(5'd0);
    add_item(KIND_SET, 4'd0, 32'h1, 5'd0);
    add_item(KIND_GET, 4'd0, 32'h0, 5'd0);
    add_random(60);
    wait_idle();

    // beyond the array size, clamped
    write_length(5'd31);
    add_item(KIND_GET, 4'd15, 32'h0, 5'd0);
    add_random(250);
    wait_idle();

    write_length(5'($urandom_range(2, 15)));
    add_random(300);
    wait_idle();

    // full length again; fill every snapshot slot and go past it
    write_length(5'd16);
    while (gen_snaps < NUM_SNAPS) begin
      add_item(KIND_SET, 4'($urandom_range(0, 15)), $urandom, 5'd0);
      add_item(KIND_SNAP, 4'($urandom_range(0, 15)), $urandom, 5'($urandom_range(0, 31)));
    end
    add_item(KIND_SNAP, 4'd0, 32'h0, 5'd0);
    add_item(KIND_SNAP, 4'd15, 32'hffff_ffff, 5'd31);
    add_item(KIND_GET, 4'd3, 32'h0, 5'd16);
    add_item(KIND_GET, 4'd3, 32'h0, 5'd17);
    add_random(400);
    wait_idle();

    no_idle = 1'b1;
    add_random(200);
    wait_idle();

    if (fail_count == 0 && expected_resp.size() == 0) begin
      $display("tb_snapshot_array_store: PASS");
    end else begin
      $display("tb_snapshot_array_store: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_snapshot_array_store: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/sas_pkg.sv
rtl/sas_ram.sv
rtl/snapshot_array_store.sv
test/tb_snapshot_array_store.sv
